// ----- rtl/flash_word_program_sequencer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the flash word program sequencer
// Expect a clk and rst in scope at the point of use.
// ---------------------------------------------------------------------------
`ifndef FLASH_WORD_PROGRAM_SEQUENCER_CORE_ASSERT_SVH
`define FLASH_WORD_PROGRAM_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define FWPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwps assertion failed");

// next-cycle implication
`define FWPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwps assertion failed");

`endif

// ----- rtl/fwps_pkg.sv -----
// ---------------------------------------------------------------------------
// fwps_pkg
// Types and constants for the flash word program sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwps_pkg;

  localparam int ADDR_WIDTH_DEF = 20;
  localparam int DATA_WIDTH_DEF = 16;

  // configuration port
  localparam int                 PADDR_WIDTH      = 2;
  localparam int                 PDATA_WIDTH      = 32;
  localparam logic [PADDR_WIDTH-1:0] REG_TIMEOUT_ADDR = 2'd0;

  localparam int                 TICK_WIDTH    = 16;
  localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = 16'd5000;

  // flash command set
  localparam int        CMD_REG_ADDR    = 0;
  localparam int        STATUS_REG_ADDR = 0;
  localparam logic [7:0] CMD_PROGRAM    = 8'h40;
  localparam logic [7:0] CMD_RESET      = 8'hFF;
  localparam logic [7:0] ST_READY_VAL   = 8'h80;
  localparam int        ST_READY_BIT    = 7;
  localparam int        ST_PROGRAM_BIT  = 4;
  localparam int        ST_VPP_BIT      = 3;
  localparam int        ST_PROTECT_BIT  = 1;

  // input function codes
  localparam logic [1:0] FUNC_START     = 2'd0;
  localparam logic [1:0] FUNC_READ_DATA = 2'd1;
  localparam logic [1:0] FUNC_TICK      = 2'd2;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;
  localparam int GEN_MAX  = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STATUS,
    PH_READBACK
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_DONE
  } kind_t;

  typedef enum logic [2:0] {
    RC_OK,
    RC_VPP,
    RC_PROGRAM,
    RC_PROTECT,
    RC_UNKNOWN,
    RC_TIMEOUT,
    RC_MISMATCH
  } rc_t;

endpackage

// ----- rtl/flash_word_program_sequencer_core.sv -----
// ---------------------------------------------------------------------------
// flash_word_program_sequencer_core
// One-word program sequencer for a flash with the common command set.
// ---------------------------------------------------------------------------
// Each accepted item is decoded in the cycle it is taken and its bus requests
// or completion (up to three transactions) go into a four-entry result queue
// that drains one transaction per cycle while result_stall is low. The input
// stalls while the queue holds more than one entry, so a start, which makes
// three transactions, holds off the next item until the queue drains to one;
// reads and ticks pass at one item per cycle while the result side keeps
// taking transactions; the single-entry-per-cycle queue read port sets the rate.
`timescale 1ns / 1ps

module flash_word_program_sequencer_core #(
  parameter int ADDR_WIDTH = fwps_pkg::ADDR_WIDTH_DEF,
  parameter int DATA_WIDTH = fwps_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fwps_pkg::PADDR_WIDTH-1:0]   paddr,
  input  logic [fwps_pkg::PDATA_WIDTH-1:0]   pwdata,
  output logic [fwps_pkg::PDATA_WIDTH-1:0]   prdata,
  output logic                               pready,
  // items
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         func,
  input  logic [ADDR_WIDTH-1:0]              word_offset,
  input  logic [DATA_WIDTH-1:0]              program_value,
  input  logic [DATA_WIDTH-1:0]              read_value,
  // results
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [1:0]                         kind,
  output logic [ADDR_WIDTH-1:0]              bus_address,
  output logic [DATA_WIDTH-1:0]              bus_write_data,
  output logic [2:0]                         result_code,
  output logic                               last
);

  import fwps_pkg::*;

  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_WIDTH-1:0] addr;
    logic [DATA_WIDTH-1:0] data;
    rc_t                   code;
    logic                  last;
  } result_t;

  phase_t                phase, phase_next;
  logic [ADDR_WIDTH-1:0] saved_offset;
  logic [DATA_WIDTH-1:0] saved_value;
  logic [TICK_WIDTH-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [TICK_WIDTH-1:0] timeout_ticks;

  result_t               rq_mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   rq_wr_ptr, rq_rd_ptr;
  logic [RQ_CNT_W-1:0]   rq_count;
  logic                  rq_pop;

  result_t               gen [GEN_MAX];
  logic [1:0]            gen_count;
  logic                  item_acc;
  logic                  load_start;
  logic                  cfg_wr;
  logic                  status_ready;
  logic                  status_clean;
  logic                  timed_out;
  rc_t                   err_code;
  result_t               rq_head;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_TIMEOUT_ADDR);
  assign prdata = (paddr == REG_TIMEOUT_ADDR) ? PDATA_WIDTH'(timeout_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_ticks <= pwdata[TICK_WIDTH-1:0];
    end
  end

  // handshakes
  assign item_stall   = rq_count > RQ_CNT_W'(RQ_DEPTH - GEN_MAX);
  assign item_acc     = item_valid && !item_stall;
  assign result_valid = rq_count != '0;
  assign rq_pop       = result_valid && !result_stall;

  // status decode
  assign status_ready = read_value[ST_READY_BIT];
  assign status_clean = read_value == DATA_WIDTH'(ST_READY_VAL);
  assign timed_out    = elapsed_ticks >= timeout_ticks;

  always_comb begin
    if (read_value[ST_VPP_BIT]) begin
      err_code = RC_VPP;
    end else if (read_value[ST_PROGRAM_BIT]) begin
      err_code = RC_PROGRAM;
    end else if (read_value[ST_PROTECT_BIT]) begin
      err_code = RC_PROTECT;
    end else begin
      err_code = RC_UNKNOWN;
    end
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      elapsed_ticks <= '0;
    end else begin
      phase         <= phase_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  assign load_start = item_acc && (phase == PH_IDLE) && (func == FUNC_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_offset <= '0;
      saved_value  <= '0;
    end else if (load_start) begin
      saved_offset <= word_offset;
      saved_value  <= program_value;
    end
  end

  // next phase and the transactions this item produces
  always_comb begin
    phase_next         = phase;
    elapsed_ticks_next = elapsed_ticks;
    gen_count          = 2'd0;
    for (int i = 0; i < GEN_MAX; i++) begin
      gen[i] = '0;
    end

    if (item_acc) begin
      unique case (phase)
        PH_IDLE: begin
          if (func == FUNC_START) begin
            gen[0].kind        = KIND_WRITE;
            gen[0].addr        = ADDR_WIDTH'(CMD_REG_ADDR);
            gen[0].data        = DATA_WIDTH'(CMD_PROGRAM);
            gen[1].kind        = KIND_WRITE;
            gen[1].addr        = word_offset;
            gen[1].data        = program_value;
            gen[2].kind        = KIND_READ;
            gen[2].addr        = ADDR_WIDTH'(STATUS_REG_ADDR);
            gen[2].last        = 1'b1;
            gen_count          = 2'd3;
            elapsed_ticks_next = '0;
            phase_next         = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (func == FUNC_TICK) begin
            if (!timed_out) begin
              elapsed_ticks_next = elapsed_ticks + 1'b1;
            end
          end else if (func == FUNC_READ_DATA) begin
            if (!status_ready) begin
              gen[0].last = 1'b1;
              gen_count   = 2'd1;
              if (timed_out) begin
                gen[0].kind = KIND_DONE;
                gen[0].code = RC_TIMEOUT;
                phase_next  = PH_IDLE;
              end else begin
                gen[0].kind = KIND_READ;
                gen[0].addr = ADDR_WIDTH'(STATUS_REG_ADDR);
              end
            end else if (!status_clean) begin
              // error bits: clear the device, then report
              gen[0].kind = KIND_WRITE;
              gen[0].addr = ADDR_WIDTH'(CMD_REG_ADDR);
              gen[0].data = DATA_WIDTH'(CMD_RESET);
              gen[1].kind = KIND_DONE;
              gen[1].code = err_code;
              gen[1].last = 1'b1;
              gen_count   = 2'd2;
              phase_next  = PH_IDLE;
            end else begin
              gen[0].kind = KIND_READ;
              gen[0].addr = saved_offset;
              gen[0].last = 1'b1;
              gen_count   = 2'd1;
              phase_next  = PH_READBACK;
            end
          end
        end
        PH_READBACK: begin
          if (func == FUNC_READ_DATA) begin
            gen[0].kind = KIND_DONE;
            gen[0].code = (read_value == saved_value) ? RC_OK : RC_MISMATCH;
            gen[0].last = 1'b1;
            gen_count   = 2'd1;
            phase_next  = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    for (int i = 0; i < GEN_MAX; i++) begin
      if (2'(i) < gen_count) begin
        rq_mem[rq_wr_ptr + RQ_PTR_W'(i)] <= gen[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= '0;
      rq_rd_ptr <= '0;
      rq_count  <= '0;
    end else begin
      rq_wr_ptr <= rq_wr_ptr + RQ_PTR_W'(gen_count);
      rq_rd_ptr <= rq_rd_ptr + RQ_PTR_W'(rq_pop);
      rq_count  <= rq_count + RQ_CNT_W'(gen_count) - RQ_CNT_W'(rq_pop);
    end
  end

  assign rq_head        = rq_mem[rq_rd_ptr];
  assign kind           = rq_head.kind;
  assign bus_address    = rq_head.addr;
  assign bus_write_data = rq_head.data;
  assign result_code    = rq_head.code;
  assign last           = rq_head.last;

  `include "flash_word_program_sequencer_core_assert.svh"

  `FWPS_ASSERT_NOW(a_rq_bound, 1'b1, rq_count <= RQ_CNT_W'(RQ_DEPTH))
  `FWPS_ASSERT_NEXT(a_start_burst, load_start, rq_count == $past(rq_count) + RQ_CNT_W'(GEN_MAX) - RQ_CNT_W'($past(rq_pop)))
  `FWPS_ASSERT_NEXT(a_timeout_idle, item_acc && func == FUNC_READ_DATA && phase == PH_STATUS && !status_ready && timed_out, phase == PH_IDLE)

endmodule
